/* hdl/pfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types, constants and helpers of the per-flow token bucket policer.
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int FLOW_ENTRIES_DEF = 4096;
    localparam int WAYS_DEF         = 4;

    localparam int RATE_W    = 34;
    localparam int CFG_IDX_W = 8;
    localparam int NUM_RATES = 4;
    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_OTHER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_VOICE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_VIDEO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BULK  = 8'd3;

    localparam logic [RATE_W-1:0] RATE_OTHER_RST = 34'd1250000;
    localparam logic [RATE_W-1:0] RATE_VOICE_RST = 34'd125000;
    localparam logic [RATE_W-1:0] RATE_VIDEO_RST = 34'd625000;
    localparam logic [RATE_W-1:0] RATE_BULK_RST  = 34'd62500;

    localparam logic [31:0] HASH_MULT  = 32'h2C1B3C6D;
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_VOICE = 2'd1,
        CLS_VIDEO = 2'd2,
        CLS_BULK  = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MOD, ST_LOOK, ST_CHK, ST_MUL, ST_DIV, ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [13:0] bytes;
        logic [63:0] now;
        class_t      cls;
        logic [31:0] hash;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [63:0]       addrs;
        logic [39:0]       ports;
        logic [RATE_W-1:0] tokens;
        logic [RATE_W-1:0] rate;
        logic [63:0]       stamp;
    } entry_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_status_t;

    function automatic class_t class_of(input logic [15:0] port);
        class_t c;
        c = CLS_OTHER;
        if (port == 16'd5060 || port == 16'd5061 || port == 16'd4500)
            c = CLS_VOICE;
        else if (port == 16'd1935 || port == 16'd1194 ||
                 (port >= 16'd6881 && port <= 16'd6999))
            c = CLS_VIDEO;
        else if (port == 16'd21 || port == 16'd25 || port == 16'd110 || port == 16'd143)
            c = CLS_BULK;
        return c;
    endfunction

endpackage

/* hdl/pfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_front
// Input stage: classifies the packet and hashes its five-tuple (two stages).
// ----------------------------------------------------------------------------
module pfp_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pfp_pkg::item_t  in_item,
    output logic            push,
    output pfp_pkg::item_t  push_item,
    input  logic            q_full
);

    logic           a_valid_reg, a_valid_next;
    logic           b_valid_reg, b_valid_next;
    pfp_pkg::item_t a_item_reg, a_item_next;
    pfp_pkg::item_t b_item_reg, b_item_next;
    logic           b_load, a_load;
    logic [31:0]    x;

    assign push    = b_valid_reg && !q_full;
    assign b_load  = !b_valid_reg || push;
    assign in_ready = !a_valid_reg || b_load;
    assign a_load  = in_valid && in_ready;

    always_comb
    begin
        x = in_item.src ^ in_item.dst ^ {in_item.sport, in_item.dport} ^ {24'd0, in_item.proto};
        a_item_next       = in_item;
        a_item_next.cls   = pfp_pkg::class_of(in_item.dport);
        a_item_next.hash  = x ^ (x >> 15);
        b_item_next       = a_item_reg;
        b_item_next.hash  = 32'(a_item_reg.hash * pfp_pkg::HASH_MULT);
        a_valid_next      = a_load ? 1'b1 : (a_valid_reg && !b_load);
        b_valid_next      = b_load ? a_valid_reg : b_valid_reg;
        push_item         = b_item_reg;
        push_item.hash    = b_item_reg.hash ^ (b_item_reg.hash >> 12);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
            a_item_reg <= a_item_next;
        if (b_load && a_valid_reg)
            b_item_reg <= b_item_next;
    end

endmodule

/* hdl/pfp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module pfp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pfp_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output pfp_pkg::item_t  head
);

    pfp_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hdl/pfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_back
// Flow table lookup, bucket refill (serial multiply, reciprocal divide), LRU.
// ----------------------------------------------------------------------------
module pfp_back
#(
    parameter int FLOW_ENTRIES = pfp_pkg::FLOW_ENTRIES_DEF,
    parameter int WAYS         = pfp_pkg::WAYS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [pfp_pkg::NUM_RATES-1:0][pfp_pkg::RATE_W-1:0] rates,
    input  logic                                    q_valid,
    input  pfp_pkg::item_t                          head,
    output pfp_pkg::back_status_t                   status,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    out_pass,
    output logic [1:0]                              out_class,
    output logic                                    out_created
);

    localparam int SETS  = FLOW_ENTRIES / WAYS;
    localparam int DEPTH = SETS * WAYS;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W = WAYS * WAY_W;
    localparam int MOD_W = SET_W + 1;
    localparam int RW    = pfp_pkg::RATE_W;

    // hash / SETS = (hash * HASH_RECIP) >> HASH_SH, exact for any 32-bit hash
    localparam int          HASH_SH    = 32 + SET_W;
    localparam logic [32:0] HASH_RECIP =
        33'(((65'd1 << HASH_SH) / 65'(SETS)) + 65'd1);
    // x / 1e9 = ((x >> 9) * SEC_RECIP) >> SEC_SH, exact for any 64-bit x
    localparam int          SEC_SH     = 76;
    localparam logic [55:0] SEC_RECIP  =
        56'(((77'd1 << SEC_SH) / 77'd1953125) + 77'd1);

    pfp_pkg::entry_t   ent_mem [DEPTH];
    logic [AGE_W-1:0]  age_mem [SETS];

    pfp_pkg::back_state_t state_reg, state_next;
    pfp_pkg::item_t    item_reg, item_next;
    logic [MOD_W-1:0]  rem_reg, rem_next;
    logic [31:0]       hq_reg, hq_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic              hit_reg, hit_next;
    logic [RW-1:0]     tok_reg, tok_next;
    logic [RW-1:0]     erate_reg, erate_next;
    logic [63:0]       prod_reg, prod_next;
    logic [29:0]       emul_reg, emul_next;
    logic [111:0]      acc_reg, acc_next;
    logic [IDX_W:0]    clr_reg, clr_next;
    logic              ov_reg, ov_next;
    logic              op_reg, op_next;
    logic [1:0]        oc_reg, oc_next;
    logic              on_reg, on_next;

    pfp_pkg::entry_t   ent_rd_reg;
    logic [AGE_W-1:0]  age_rd_reg;

    logic              ent_we, age_we, pop;
    logic [IDX_W-1:0]  ent_wa;
    pfp_pkg::entry_t   ent_wd;
    logic [SET_W-1:0]  age_wa, set_idx;
    logic [AGE_W-1:0]  age_wd;
    logic [IDX_W-1:0]  rd_addr;
    logic [64:0]       hprod;
    logic [63:0]       elapsed;
    logic [27:0]       dia, dib;
    logic [55:0]       dpp;
    logic [111:0]      dpart;
    logic [RW:0]       sum;
    logic              pass;
    logic [WAY_W-1:0]  pos;
    logic              match;

    assign set_idx = rem_reg[SET_W-1:0];
    assign rd_addr = IDX_W'(set_idx) * IDX_W'(WAYS) + IDX_W'(way_reg);
    assign status.clearing = (state_reg == pfp_pkg::ST_CLEAR);
    assign status.pop      = pop;
    assign out_valid   = ov_reg;
    assign out_pass    = op_reg;
    assign out_class   = oc_reg;
    assign out_created = on_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        rem_next   = rem_reg;
        hq_next    = hq_reg;
        cnt_next   = cnt_reg;
        way_next   = way_reg;
        hit_next   = hit_reg;
        tok_next   = tok_reg;
        erate_next = erate_reg;
        prod_next  = prod_reg;
        emul_next  = emul_reg;
        acc_next   = acc_reg;
        clr_next   = clr_reg;
        ov_next    = ov_reg && !out_ready;
        op_next    = op_reg;
        oc_next    = oc_reg;
        on_next    = on_reg;
        pop        = 1'b0;
        ent_we     = 1'b0;
        ent_wa     = rd_addr;
        ent_wd     = '0;
        age_we     = 1'b0;
        age_wa     = set_idx;
        age_wd     = '0;
        hprod      = '0;
        dia        = '0;
        dib        = '0;
        dpp        = '0;
        dpart      = '0;
        sum        = '0;
        pass       = 1'b1;
        pos        = '0;
        elapsed    = item_reg.now - ent_rd_reg.stamp;
        match      = ent_rd_reg.valid && ent_rd_reg.addrs == {item_reg.src, item_reg.dst} &&
                     ent_rd_reg.ports == {item_reg.sport, item_reg.dport, item_reg.proto};

        case (state_reg)
            pfp_pkg::ST_CLEAR:
            begin
                ent_we = 1'b1;
                ent_wa = clr_reg[IDX_W-1:0];
                if (clr_reg < (IDX_W+1)'(SETS))
                begin
                    age_we = 1'b1;
                    age_wa = clr_reg[SET_W-1:0];
                    for (int i = 0; i < WAYS; i++)
                        age_wd[i*WAY_W +: WAY_W] = WAY_W'(i);
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (IDX_W+1)'(DEPTH - 1))
                    state_next = pfp_pkg::ST_IDLE;
            end
            pfp_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    item_next  = head;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = pfp_pkg::ST_MOD;
                end
            end
            pfp_pkg::ST_MOD:
            begin
                // set = hash mod SETS: quotient by reciprocal, then remainder
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd0)
                begin
                    hprod   = 65'(item_reg.hash) * 65'(HASH_RECIP);
                    hq_next = 32'(hprod >> HASH_SH);
                end
                else
                begin
                    rem_next   = MOD_W'(item_reg.hash - hq_reg * 32'(SETS));
                    way_next   = '0;
                    state_next = pfp_pkg::ST_LOOK;
                end
            end
            pfp_pkg::ST_LOOK:
                state_next = pfp_pkg::ST_CHK;
            pfp_pkg::ST_CHK:
            begin
                if (match)
                begin
                    hit_next   = 1'b1;
                    tok_next   = ent_rd_reg.tokens;
                    erate_next = ent_rd_reg.rate;
                    prod_next  = '0;
                    cnt_next   = '0;
                    emul_next  = (elapsed > 64'(pfp_pkg::NS_PER_SEC)) ?
                                 pfp_pkg::NS_PER_SEC : elapsed[29:0];
                    state_next = (elapsed == 64'd0) ? pfp_pkg::ST_DONE : pfp_pkg::ST_MUL;
                end
                else if (way_reg == WAY_W'(WAYS - 1))
                begin
                    hit_next   = 1'b0;
                    way_next   = age_rd_reg[WAY_W-1:0];
                    erate_next = rates[item_reg.cls];
                    state_next = pfp_pkg::ST_DONE;
                end
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = pfp_pkg::ST_LOOK;
                end
            end
            pfp_pkg::ST_MUL:
            begin
                prod_next = (prod_reg << 1) + (emul_reg[29] ? 64'(erate_reg) : 64'd0);
                emul_next = emul_reg << 1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 6'd29)
                begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = pfp_pkg::ST_DIV;
                end
            end
            pfp_pkg::ST_DIV:
            begin
                // four 28x28 partial products of (prod >> 9) * SEC_RECIP, then refill
                if (cnt_reg == 6'd4)
                begin
                    sum        = {1'b0, tok_reg} + acc_reg[SEC_SH +: RW+1];
                    tok_next   = (sum > {1'b0, erate_reg}) ? erate_reg : sum[RW-1:0];
                    state_next = pfp_pkg::ST_DONE;
                end
                else
                begin
                    dia = cnt_reg[1] ? {1'b0, prod_reg[63:37]} : prod_reg[36:9];
                    dib = cnt_reg[0] ? SEC_RECIP[55:28] : SEC_RECIP[27:0];
                    dpp = 56'(dia) * 56'(dib);
                    if (cnt_reg[1:0] == 2'd0)
                        dpart = {56'd0, dpp};
                    else if (cnt_reg[1:0] == 2'd3)
                        dpart = {dpp, 56'd0};
                    else
                        dpart = {28'd0, dpp, 28'd0};
                    acc_next = acc_reg + dpart;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pfp_pkg::ST_DONE:
            begin
                pass = hit_reg ? (tok_reg >= RW'(item_reg.bytes)) : 1'b1;
                // most recently used list: drop the way, append it at the top
                for (int i = 0; i < WAYS; i++)
                    if (age_rd_reg[i*WAY_W +: WAY_W] == way_reg)
                        pos = WAY_W'(i);
                for (int i = 0; i < WAYS; i++)
                begin
                    if (i == WAYS - 1)
                        age_wd[i*WAY_W +: WAY_W] = way_reg;
                    else if (WAY_W'(i) < pos)
                        age_wd[i*WAY_W +: WAY_W] = age_rd_reg[i*WAY_W +: WAY_W];
                    else
                        age_wd[i*WAY_W +: WAY_W] = age_rd_reg[(i+1)*WAY_W +: WAY_W];
                end
                ent_wd.valid  = 1'b1;
                ent_wd.addrs  = {item_reg.src, item_reg.dst};
                ent_wd.ports  = {item_reg.sport, item_reg.dport, item_reg.proto};
                ent_wd.rate   = erate_reg;
                ent_wd.stamp  = item_reg.now;
                ent_wd.tokens = !hit_reg ? erate_reg :
                                (pass ? tok_reg - RW'(item_reg.bytes) : tok_reg);
                if (!ov_reg || out_ready)
                begin
                    ent_we     = 1'b1;
                    age_we     = 1'b1;
                    ov_next    = 1'b1;
                    op_next    = pass;
                    oc_next    = item_reg.cls;
                    on_next    = !hit_reg;
                    state_next = pfp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pfp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfp_pkg::ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        rem_reg   <= rem_next;
        hq_reg    <= hq_next;
        cnt_reg   <= cnt_next;
        way_reg   <= way_next;
        hit_reg   <= hit_next;
        tok_reg   <= tok_next;
        erate_reg <= erate_next;
        prod_reg  <= prod_next;
        emul_reg  <= emul_next;
        acc_reg   <= acc_next;
        op_reg    <= op_next;
        oc_reg    <= oc_next;
        on_reg    <= on_next;
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_wa] <= ent_wd;
        ent_rd_reg <= ent_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (age_we)
            age_mem[age_wa] <= age_wd;
        age_rd_reg <= age_mem[set_idx];
    end

endmodule

/* hdl/per_flow_token_bucket_policer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_token_bucket_policer
// Classifies packets by port and polices each flow with its own token bucket.
// ----------------------------------------------------------------------------
// Path: after the input transfer a packet passes the front stages and the
// queue, then the back part probes the ways of its set in turn; a hit with a
// changed timestamp first computes a refill (serial multiply, reciprocal
// divide by 1e9). One packet in the back part at a time: the next is taken from
// the queue once the result is registered, which stalls on m_axis_tready.
// Reset: asynchronous, active low; a clearing pass then sweeps the flow table
// (and LRU lists); packets queue meanwhile.
module per_flow_token_bucket_policer
#(
    parameter int FLOW_ENTRIES = pfp_pkg::FLOW_ENTRIES_DEF,
    parameter int WAYS         = pfp_pkg::WAYS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // tdata: source_address, dest_address, source_port, dest_port,
    //        ip_protocol, packet_bytes, time_ns, zero pad
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [pfp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tdata: pass_packet, traffic_class[1:0], flow_created, zero pad
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pfp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [pfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfp_pkg::RATE_W-1:0]       cfg_data
);

    // class rates, sampled into an entry when the flow is created
    logic [pfp_pkg::NUM_RATES-1:0][pfp_pkg::RATE_W-1:0] rate_reg;

    pfp_pkg::item_t       in_item, push_item, head;
    pfp_pkg::back_status_t bst;
    logic push, q_full, q_valid;
    logic o_pass, o_new;
    logic [1:0] o_cls;

    always_comb
    begin
        in_item       = '0;
        in_item.src   = s_axis_tdata[31:0];
        in_item.dst   = s_axis_tdata[63:32];
        in_item.sport = s_axis_tdata[79:64];
        in_item.dport = s_axis_tdata[95:80];
        in_item.proto = s_axis_tdata[103:96];
        in_item.bytes = s_axis_tdata[117:104];
        in_item.now   = s_axis_tdata[181:118];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg[pfp_pkg::REG_RATE_OTHER[1:0]] <= pfp_pkg::RATE_OTHER_RST;
            rate_reg[pfp_pkg::REG_RATE_VOICE[1:0]] <= pfp_pkg::RATE_VOICE_RST;
            rate_reg[pfp_pkg::REG_RATE_VIDEO[1:0]] <= pfp_pkg::RATE_VIDEO_RST;
            rate_reg[pfp_pkg::REG_RATE_BULK[1:0]]  <= pfp_pkg::RATE_BULK_RST;
        end
        else if (cfg_we && cfg_index <= pfp_pkg::REG_RATE_BULK)
        begin
            rate_reg[cfg_index[1:0]] <= cfg_data;  // out of range index ignored
        end
    end

    // front: classify and hash
    pfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    pfp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (bst.pop),
        .q_valid   (q_valid),
        .head      (head)
    );

    // back: table lookup, bucket update, result register
    pfp_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .WAYS         (WAYS)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rates       (rate_reg),
        .q_valid     (q_valid),
        .head        (head),
        .status      (bst),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_pass    (o_pass),
        .out_class   (o_cls),
        .out_created (o_new)
    );

    assign m_axis_tdata = {4'd0, o_new, o_cls, o_pass};

    // no result can appear while the table is being swept
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bst.clearing |-> !m_axis_tvalid)
        else $error("result presented during clearing pass");

    // back part only takes an item that the queue holds
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bst.pop |-> q_valid && !bst.clearing)
        else $error("pop from empty queue");

    // front never pushes into a full queue
    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");

endmodule
